@@ hw/rtl/ialt_pkg.sv @@
// Shared types, codes and character constants for the indent-aware tokenizer.
package ialt_pkg;

	localparam int COUNT_WIDTH_DEF = 16;
	localparam int RQ_DEPTH        = 4;
	localparam int RQ_PW           = $clog2(RQ_DEPTH);
	localparam int OUT_CW          = 16;

	localparam logic [1:0] KIND_INDENT = 2'd0;
	localparam logic [1:0] KIND_BYTE   = 2'd1;
	localparam logic [1:0] KIND_END    = 2'd2;

	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_VT     = 8'h0B;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_BTICK  = 8'h60;
	localparam logic [7:0] CH_AT     = 8'h40;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_TILDE  = 8'h7E;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	typedef enum logic [2:0] {
		M_INIT    = 3'd0,
		M_INDENT  = 3'd1,
		M_COMMENT = 3'd2,
		M_BETWEEN = 3'd3,
		M_WORD    = 3'd4,
		M_STRING  = 3'd5,
		M_ESCAPE  = 3'd6,
		M_UNQUOTE = 3'd7
	} ialt_mode_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [7:0]        byte_out;
		logic              first_byte;
		logic [OUT_CW-1:0] indent_level;
		logic [OUT_CW-1:0] spaces_before;
	} ialt_res_t;

	// all results caused by one input byte, res[0] goes out first
	typedef struct packed {
		logic [1:0]           n;
		ialt_res_t [2:0]      res;
	} ialt_grp_t;

	function automatic logic is_ws(logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_NL || c == CH_CR ||
			c == CH_VT || c == CH_FF;
	endfunction

	function automatic logic is_punct(logic [7:0] c);
		return c == CH_LPAREN || c == CH_RPAREN || c == CH_SEMI || c == CH_DQUOTE;
	endfunction

	function automatic logic is_quote(logic [7:0] c);
		return c == CH_COMMA || c == CH_SQUOTE || c == CH_BTICK || c == CH_AT;
	endfunction

	function automatic logic is_ssyntax(logic [7:0] c);
		return c == CH_COLON || c == CH_TILDE || c == CH_BANG || c == CH_DOT ||
			c == CH_AMP;
	endfunction

	function automatic ialt_res_t mk_res(logic [1:0] kind, logic [7:0] b, logic first,
			logic [OUT_CW-1:0] ind, logic [OUT_CW-1:0] sp);
		ialt_res_t r;
		r.kind          = kind;
		r.byte_out      = b;
		r.first_byte    = first;
		r.indent_level  = ind;
		r.spaces_before = sp;
		return r;
	endfunction

	function automatic ialt_grp_t grp_put(ialt_grp_t g, ialt_res_t r);
		ialt_grp_t o;
		o = g;
		case (g.n)
			2'd0: o.res[0] = r;
			2'd1: o.res[1] = r;
			2'd2: o.res[2] = r;
			default: ;
		endcase
		if (g.n != 2'd3)
			o.n = g.n + 2'd1;
		return o;
	endfunction

endpackage

@@ hw/rtl/ialt_core.sv @@
// Tokenizer state machine: consumes one byte per beat and builds its result group.
module ialt_core #(
	parameter int COUNT_WIDTH = ialt_pkg::COUNT_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                acc,
	input  logic [7:0]          ch,
	input  logic                end_of_input,
	output logic                push,
	output ialt_pkg::ialt_grp_t grp
);
	import ialt_pkg::*;

	localparam int CWP = COUNT_WIDTH + 1;

	ialt_mode_t             mode_q, mode_d;
	logic [COUNT_WIDTH-1:0] indent_cnt_q, indent_cnt_d;
	logic [COUNT_WIDTH-1:0] cur_indent_q, cur_indent_d;
	logic [COUNT_WIDTH-1:0] space_cnt_q, space_cnt_d;
	logic [7:0]             prev_byte_q, prev_byte_d;
	logic                   colon_q, colon_d;
	logic                   do_btw, do_start;
	logic [COUNT_WIDTH-1:0] sp_save;
	ialt_grp_t              g;

	function automatic logic [COUNT_WIDTH-1:0] sat_add(logic [COUNT_WIDTH-1:0] a,
			logic [1:0] k);
		logic [COUNT_WIDTH:0] s;
		s = {1'b0, a} + CWP'(k);
		return s[COUNT_WIDTH] ? '1 : s[COUNT_WIDTH-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= M_INIT;
			indent_cnt_q <= '0;
			cur_indent_q <= '0;
			space_cnt_q  <= '0;
			prev_byte_q  <= '0;
			colon_q      <= 1'b0;
		end else if (acc) begin
			mode_q       <= mode_d;
			indent_cnt_q <= indent_cnt_d;
			cur_indent_q <= cur_indent_d;
			space_cnt_q  <= space_cnt_d;
			prev_byte_q  <= prev_byte_d;
			colon_q      <= colon_d;
		end
	end

	always_comb begin
		mode_d       = mode_q;
		indent_cnt_d = indent_cnt_q;
		cur_indent_d = cur_indent_q;
		space_cnt_d  = space_cnt_q;
		prev_byte_d  = prev_byte_q;
		colon_d      = colon_q;
		do_btw       = 1'b0;
		do_start     = 1'b0;
		sp_save      = '0;
		g            = '0;

		if (end_of_input) begin
			if (mode_q == M_WORD) begin
				if (!colon_q)
					g = grp_put(g, mk_res(KIND_END, '0, 1'b0, '0, '0));
			end else if (mode_q == M_STRING || mode_q == M_ESCAPE ||
					mode_q == M_UNQUOTE) begin
				g = grp_put(g, mk_res(KIND_END, '0, 1'b0, '0, '0));
			end
			mode_d       = M_INIT;
			indent_cnt_d = '0;
			cur_indent_d = '0;
			space_cnt_d  = '0;
			prev_byte_d  = '0;
			colon_d      = 1'b0;
		end else begin
			case (mode_q)
				M_INIT, M_INDENT: begin
					if (ch == CH_SEMI) begin
						mode_d = M_COMMENT;
					end else if (ch == CH_NL) begin
						indent_cnt_d = '0;
					end else if (ch == CH_SPACE) begin
						indent_cnt_d = sat_add(indent_cnt_q, 2'd1);
					end else if (ch == CH_TAB) begin
						indent_cnt_d = sat_add(indent_cnt_q, 2'd2);
					end else if (!is_ws(ch)) begin
						cur_indent_d = indent_cnt_q;
						g = grp_put(g, mk_res(KIND_INDENT, '0, 1'b0,
							OUT_CW'(indent_cnt_q), '0));
						space_cnt_d = '0;
						do_start    = 1'b1;
					end
				end
				M_COMMENT: begin
					if (ch == CH_NL) begin
						mode_d       = M_INDENT;
						indent_cnt_d = '0;
					end
				end
				M_BETWEEN: begin
					do_btw = 1'b1;
				end
				M_WORD: begin
					if (is_ws(ch) || is_punct(ch) ||
							(is_quote(ch) && !is_ssyntax(prev_byte_q))) begin
						// close the word; a held lone colon vanishes
						if (colon_q)
							colon_d = 1'b0;
						else
							g = grp_put(g, mk_res(KIND_END, '0, 1'b0, '0, '0));
						space_cnt_d = '0;
						mode_d      = M_BETWEEN;
						do_btw      = 1'b1;
					end else begin
						if (colon_q) begin
							g = grp_put(g, mk_res(KIND_BYTE, CH_COLON, 1'b1,
								OUT_CW'(cur_indent_q), OUT_CW'(space_cnt_q)));
							space_cnt_d = '0;
							colon_d     = 1'b0;
						end
						g = grp_put(g, mk_res(KIND_BYTE, ch, 1'b0, '0, '0));
						prev_byte_d = ch;
					end
				end
				M_STRING: begin
					g = grp_put(g, mk_res(KIND_BYTE, ch, 1'b0, '0, '0));
					if (ch == CH_BSLASH) begin
						mode_d = M_ESCAPE;
					end else if (ch == CH_DQUOTE) begin
						g = grp_put(g, mk_res(KIND_END, '0, 1'b0, '0, '0));
						space_cnt_d = '0;
						mode_d      = M_BETWEEN;
					end
				end
				M_ESCAPE: begin
					g = grp_put(g, mk_res(KIND_BYTE, ch, 1'b0, '0, '0));
					mode_d = M_STRING;
				end
				M_UNQUOTE: begin
					if (ch == CH_AT) begin
						g = grp_put(g, mk_res(KIND_BYTE, ch, 1'b0, '0, '0));
						g = grp_put(g, mk_res(KIND_END, '0, 1'b0, '0, '0));
						space_cnt_d = '0;
						mode_d      = M_BETWEEN;
					end else begin
						g = grp_put(g, mk_res(KIND_END, '0, 1'b0, '0, '0));
						space_cnt_d = '0;
						mode_d      = M_BETWEEN;
						do_btw      = 1'b1;
					end
				end
				default: ;
			endcase

			// byte seen between tokens (also the byte that ended a word or comma)
			if (do_btw) begin
				if (ch == CH_NL) begin
					mode_d       = M_INDENT;
					indent_cnt_d = '0;
					space_cnt_d  = '0;
				end else if (ch == CH_SEMI) begin
					mode_d       = M_COMMENT;
					indent_cnt_d = '0;
					space_cnt_d  = '0;
				end else if (ch == CH_SPACE) begin
					space_cnt_d = sat_add(space_cnt_d, 2'd1);
				end else if (ch == CH_TAB) begin
					space_cnt_d = sat_add(space_cnt_d, 2'd2);
				end else if (!is_ws(ch)) begin
					do_start = 1'b1;
				end
			end

			if (do_start) begin
				sp_save = space_cnt_d;
				if (ch == CH_COLON) begin
					colon_d     = 1'b1;
					prev_byte_d = ch;
					mode_d      = M_WORD;
				end else begin
					space_cnt_d = '0;
					g = grp_put(g, mk_res(KIND_BYTE, ch, 1'b1,
						OUT_CW'(cur_indent_d), OUT_CW'(sp_save)));
					if (ch == CH_DQUOTE) begin
						mode_d = M_STRING;
					end else if (ch == CH_COMMA) begin
						mode_d = M_UNQUOTE;
					end else if (ch == CH_LPAREN || ch == CH_RPAREN || is_quote(ch)) begin
						g = grp_put(g, mk_res(KIND_END, '0, 1'b0, '0, '0));
						mode_d = M_BETWEEN;
					end else begin
						prev_byte_d = ch;
						mode_d      = M_WORD;
					end
				end
			end
		end
	end

	assign grp  = g;
	assign push = acc && (g.n != 2'd0);

endmodule

@@ hw/rtl/ialt_rq.sv @@
// Result queue: holds result groups and hands them out one result per beat.
module ialt_rq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ialt_pkg::ialt_grp_t push_grp,
	output logic                full,
	output logic                res_valid,
	input  logic                res_ready,
	output ialt_pkg::ialt_res_t res,
	output logic                res_last
);
	import ialt_pkg::*;

	ialt_grp_t        mem_q [RQ_DEPTH];
	logic [RQ_PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [RQ_PW:0]   cnt_q;
	logic [1:0]       sub_q;
	ialt_grp_t        head;
	logic             pop;

	assign head      = mem_q[rd_ptr_q];
	assign res_valid = cnt_q != '0;
	assign res       = head.res[sub_q];
	assign res_last  = sub_q == (head.n - 2'd1);
	assign pop       = res_valid && res_ready && res_last;
	assign full      = cnt_q == (RQ_PW + 1)'(RQ_DEPTH);

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_grp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
			sub_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
				sub_q    <= '0;
			end else if (res_valid && res_ready) begin
				sub_q <= sub_q + 2'd1;
			end
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

@@ hw/rtl/indent_aware_lisp_tokenizer_unit.sv @@
// Top level of the indent-aware tokenizer: byte input, token result stream.
// Takes one source byte per cycle whenever the result queue has a free slot;
// each byte yields zero to three results, all produced in the cycle it is
// taken and queued as one group (the queue holds four groups). Results leave
// at one per cycle while res_ready is high, through the single result port;
// a byte with no results queues no group. Results are registered in the
// queue before they leave. An end-of-input beat closes any open token and
// returns the tokenizer to its reset state.
module indent_aware_lisp_tokenizer_unit #(
	parameter int COUNT_WIDTH = ialt_pkg::COUNT_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        src_valid,
	output logic        src_ready,
	input  logic [7:0]  ch,
	input  logic        end_of_input,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [1:0]  kind,
	output logic [7:0]  byte_out,
	output logic        first_byte,
	output logic [15:0] indent_level,
	output logic [15:0] spaces_before,
	output logic        last
);
	import ialt_pkg::*;

	logic      acc, push, full;
	ialt_grp_t grp;
	ialt_res_t res;

	assign src_ready = !full;
	assign acc       = src_valid && src_ready;

	ialt_core #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.acc          (acc),
		.ch           (ch),
		.end_of_input (end_of_input),
		.push         (push),
		.grp          (grp)
	);

	ialt_rq u_rq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_grp  (grp),
		.full      (full),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.res_last  (last)
	);

	assign kind          = res.kind;
	assign byte_out      = res.byte_out;
	assign first_byte    = res.first_byte;
	assign indent_level  = res.indent_level;
	assign spaces_before = res.spaces_before;

endmodule

@@ hw/rtl/ialt_chk.sv @@
// Port-level checker for the tokenizer, bound to the top level.
module ialt_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        src_valid,
	input logic        src_ready,
	input logic [7:0]  ch,
	input logic        end_of_input,
	input logic        res_valid,
	input logic        res_ready,
	input logic [1:0]  kind,
	input logic [7:0]  byte_out,
	input logic        first_byte,
	input logic [15:0] indent_level,
	input logic [15:0] spaces_before,
	input logic        last
);
	import ialt_pkg::*;

	// a result beat stays up until taken
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result beat dropped before acceptance");

	a_first_is_byte: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && first_byte |-> kind == KIND_BYTE)
		else $error("first_byte set on a non-byte result");

	a_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind != KIND_INDENT && !first_byte
			|-> indent_level == '0 && spaces_before == '0 && (kind == KIND_BYTE || byte_out == '0))
		else $error("stray field value on a plain result");

	// an indent token with more in its group is followed right away by the token's first byte;
	// a held colon leaves the indent token alone
	a_indent_then_first: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && kind == KIND_INDENT && !last |=> res_valid && first_byte)
		else $error("indent token not followed by a first byte");

endmodule

bind indent_aware_lisp_tokenizer_unit ialt_chk u_ialt_chk (.*);
